FILE: hw/rtl/smsdb_pkg.sv
// Shared types and constants for the double-buffered sensor matrix scanner.
// Used by hw/rtl/sensor_matrix_scan_double_buffer.sv; depends on nothing.
package smsdb_pkg;

	localparam int COLS = 16;
	localparam int ROWS = 16;
	localparam int COL_W = $clog2(COLS);
	localparam int ROW_W = $clog2(ROWS);
	localparam int ADDR_W = 1 + COL_W + ROW_W;
	localparam int DEPTH = 2 * COLS * ROWS;

	localparam int SAMPLE_W = 12;
	localparam int SUM_W = SAMPLE_W + 2;

	// Division by three as a multiply by round-up(2^16 / 3) and a shift.
	// Exact for every sum of three 12-bit samples.
	localparam int RECIP_W = 15;
	localparam logic [RECIP_W-1:0] DIV3_RECIP = RECIP_W'(21846);
	localparam int DIV3_SHIFT = 16;
	localparam int PROD_W = SUM_W + RECIP_W;

	typedef enum logic [1:0] {
		OP_CONV   = 2'd0,
		OP_READ   = 2'd1,
		OP_CLEAR  = 2'd2,
		OP_UNUSED = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_NONE    = 2'd0,
		ST_READY   = 2'd1,
		ST_OVERRUN = 2'd2,
		ST_INVALID = 2'd3
	} status_t;

	// Snapshot of the scan state that travels with an item to the output.
	typedef struct packed {
		logic [COL_W-1:0] col;
		logic [ROW_W-1:0] row;
		logic             line_sync;
		logic             frame_sync;
		status_t          status;
		logic             bank;
	} scan_info_t;

endpackage

FILE: hw/rtl/sensor_matrix_scan_double_buffer.sv
// Double-buffered raster scan of a sensor matrix with a 2 x 16 x 16 cell memory.
// A result passes through the stage 1 register (scan update and memory read) and then
// the output register (divide and memory write before it); an output stall holds stage 1.
// Throughput: one item per cycle if not stalled; the memory write and read ports set it.
// Reset (arst_n low) clears scan position, sync levels, bank and frame status at once;
// the cell memory is not cleared and a cell reads as undefined until it is written.
module sensor_matrix_scan_double_buffer (
	input  logic        clk,
	input  logic        arst_n,
	// Input stream.
	input  logic        s_tvalid,
	output logic        s_tready,
	// s_tdata, lowest bit up: op[1:0], sample_a[13:2], sample_b[25:14], sample_c[37:26],
	// read_bank[38], read_col[42:39], read_row[46:43], zero fill[47].
	input  logic [47:0] s_tdata,
	// Result stream.
	output logic        m_tvalid,
	input  logic        m_tready,
	// m_tdata, lowest bit up: cell_value[11:0], cell_col[15:12], cell_row[19:16],
	// line_sync[20], frame_sync[21], frame_status[23:22], active_bank[24], zero fill.
	output logic [31:0] m_tdata
);

	// Unpack the input transfer.
	smsdb_pkg::op_t                      in_op;
	logic [smsdb_pkg::SAMPLE_W-1:0]      in_a;
	logic [smsdb_pkg::SAMPLE_W-1:0]      in_b;
	logic [smsdb_pkg::SAMPLE_W-1:0]      in_c;
	logic                                in_rbank;
	logic [smsdb_pkg::COL_W-1:0]         in_rcol;
	logic [smsdb_pkg::ROW_W-1:0]         in_rrow;

	assign in_op    = smsdb_pkg::op_t'(s_tdata[1:0]);
	assign in_a     = s_tdata[13:2];
	assign in_b     = s_tdata[25:14];
	assign in_c     = s_tdata[37:26];
	assign in_rbank = s_tdata[38];
	assign in_rcol  = s_tdata[42:39];
	assign in_rrow  = s_tdata[46:43];

	// Scan state, updated when an item is accepted.
	logic [smsdb_pkg::COL_W-1:0] scan_col_q;
	logic [smsdb_pkg::ROW_W-1:0] scan_row_q;
	logic                        fill_bank_q;
	logic                        line_level_q;
	logic                        frame_level_q;
	smsdb_pkg::status_t          status_q;

	// Pipeline stage 1 and the output register.
	logic                           valid_s1;
	smsdb_pkg::op_t                 op_s1;
	logic [smsdb_pkg::SUM_W-1:0]    sum_s1;
	logic [smsdb_pkg::ADDR_W-1:0]   wr_addr_s1;
	logic                           in_range_s1;
	logic                           fwd_s1;
	smsdb_pkg::scan_info_t          info_s1;

	logic                           m_tvalid_q;
	logic [31:0]                    m_tdata_q;

	// Memory and its ports.
	logic [smsdb_pkg::SAMPLE_W-1:0] mem [smsdb_pkg::DEPTH];
	logic [smsdb_pkg::SAMPLE_W-1:0] rd_data_q;
	logic [smsdb_pkg::SAMPLE_W-1:0] wr_data_q;
	logic                           mem_we;
	logic                           mem_re;
	logic [smsdb_pkg::ADDR_W-1:0]   rd_addr;

	// Next scan state.
	logic [smsdb_pkg::COL_W-1:0] col_nxt;
	logic [smsdb_pkg::ROW_W-1:0] row_nxt;
	logic                        bank_nxt;
	logic                        line_nxt;
	logic                        frame_nxt;
	smsdb_pkg::status_t          status_nxt;

	logic                                  advance;
	logic                                  accept;
	logic [smsdb_pkg::SUM_W-1:0]           sum;
	logic                                  in_range;
	logic [smsdb_pkg::PROD_W-1:0]          prod;
	logic [smsdb_pkg::SAMPLE_W-1:0]        avg;
	logic [smsdb_pkg::SAMPLE_W-1:0]        value_s1;

	// The stage moves whenever the output register is free or being emptied; a new
	// transfer is taken whenever stage 1 is free or moving on.
	assign advance  = !m_tvalid_q || m_tready;
	assign s_tready = !valid_s1 || advance;
	assign accept   = s_tvalid && s_tready;

	assign sum = smsdb_pkg::SUM_W'(in_a) + smsdb_pkg::SUM_W'(in_b)
		+ smsdb_pkg::SUM_W'(in_c);
	assign in_range = ({1'b0, in_rcol} < (smsdb_pkg::COL_W + 1)'(smsdb_pkg::COLS))
		&& ({1'b0, in_rrow} < (smsdb_pkg::ROW_W + 1)'(smsdb_pkg::ROWS));
	assign rd_addr = {in_rbank, in_rcol, in_rrow};

	// A conversion advances the column first; a wrapped column advances the row and
	// toggles the line sync, unless the row wraps as well, in which case only the
	// frame sync toggles, the bank flips and the frame status is raised.
	always_comb begin
		col_nxt    = scan_col_q;
		row_nxt    = scan_row_q;
		bank_nxt   = fill_bank_q;
		line_nxt   = line_level_q;
		frame_nxt  = frame_level_q;
		status_nxt = status_q;
		case (in_op)
			smsdb_pkg::OP_CONV: begin
				if (scan_col_q == smsdb_pkg::COL_W'(smsdb_pkg::COLS - 1)) begin
					col_nxt = '0;
					if (scan_row_q == smsdb_pkg::ROW_W'(smsdb_pkg::ROWS - 1)) begin
						row_nxt   = '0;
						frame_nxt = !frame_level_q;
						bank_nxt  = !fill_bank_q;
						if (status_q == smsdb_pkg::ST_READY
							|| status_q == smsdb_pkg::ST_OVERRUN) begin
							status_nxt = smsdb_pkg::ST_OVERRUN;
						end else begin
							status_nxt = smsdb_pkg::ST_READY;
						end
					end else begin
						row_nxt  = scan_row_q + 1'b1;
						line_nxt = !line_level_q;
					end
				end else begin
					col_nxt = scan_col_q + 1'b1;
				end
			end
			smsdb_pkg::OP_CLEAR: begin
				status_nxt = smsdb_pkg::ST_NONE;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_col_q    <= '0;
			scan_row_q    <= '0;
			fill_bank_q   <= 1'b0;
			line_level_q  <= 1'b0;
			frame_level_q <= 1'b0;
			status_q      <= smsdb_pkg::ST_NONE;
		end else if (accept) begin
			scan_col_q    <= col_nxt;
			scan_row_q    <= row_nxt;
			fill_bank_q   <= bank_nxt;
			line_level_q  <= line_nxt;
			frame_level_q <= frame_nxt;
			status_q      <= status_nxt;
		end
	end

	// Stage 1 control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	// Stage 1 payload. A read that hits the cell being written in the same cycle sees
	// the old memory contents, so it is marked to take the written value instead.
	always_ff @(posedge clk) begin
		if (accept) begin
			op_s1       <= in_op;
			sum_s1      <= sum;
			wr_addr_s1  <= {bank_nxt, col_nxt, row_nxt};
			in_range_s1 <= in_range;
			fwd_s1      <= mem_we && (wr_addr_s1 == rd_addr);
			if (in_op == smsdb_pkg::OP_READ) begin
				info_s1.col <= in_rcol;
				info_s1.row <= in_rrow;
			end else begin
				info_s1.col <= col_nxt;
				info_s1.row <= row_nxt;
			end
			info_s1.line_sync  <= line_nxt;
			info_s1.frame_sync <= frame_nxt;
			info_s1.status     <= status_nxt;
			info_s1.bank       <= bank_nxt;
		end
	end

	assign prod = smsdb_pkg::PROD_W'(sum_s1) * smsdb_pkg::PROD_W'(smsdb_pkg::DIV3_RECIP);
	assign avg  = prod[smsdb_pkg::DIV3_SHIFT +: smsdb_pkg::SAMPLE_W];

	assign mem_we = valid_s1 && advance && (op_s1 == smsdb_pkg::OP_CONV);
	assign mem_re = accept && (in_op == smsdb_pkg::OP_READ);

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[wr_addr_s1] <= avg;
			wr_data_q       <= avg;
		end
		if (mem_re) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	always_comb begin
		value_s1 = '0;
		case (op_s1)
			smsdb_pkg::OP_CONV: begin
				value_s1 = avg;
			end
			smsdb_pkg::OP_READ: begin
				if (in_range_s1) begin
					value_s1 = fwd_s1 ? wr_data_q : rd_data_q;
				end
			end
			default: begin
				value_s1 = '0;
			end
		endcase
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (advance) begin
			m_tvalid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1) begin
			m_tdata_q <= {7'b0, info_s1.bank, info_s1.status, info_s1.frame_sync,
				info_s1.line_sync, info_s1.row, info_s1.col, value_s1};
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	// The frame status never takes the unused code.
	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		status_q != smsdb_pkg::ST_INVALID)
		else $error("frame status holds an unused code");

	// The scan position stays inside the matrix.
	a_scan_range: assert property (@(posedge clk) disable iff (!arst_n)
		({1'b0, scan_col_q} < (smsdb_pkg::COL_W + 1)'(smsdb_pkg::COLS))
		&& ({1'b0, scan_row_q} < (smsdb_pkg::ROW_W + 1)'(smsdb_pkg::ROWS)))
		else $error("scan position outside the matrix");

	// A stalled stage 1 item is neither lost nor replaced.
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !advance |=> valid_s1 && $stable(op_s1) && $stable(wr_addr_s1))
		else $error("stage 1 item changed while stalled");

	// A read accepted while its cell is being written is marked to take the written value.
	a_fwd_write: assert property (@(posedge clk) disable iff (!arst_n)
		accept && (in_op == smsdb_pkg::OP_READ) && mem_we && (wr_addr_s1 == rd_addr)
		|=> fwd_s1 && (wr_data_q == $past(avg)))
		else $error("read of a cell in flight missed the forwarded value");

endmodule

FILE: bench/tb_sensor_matrix_scan_double_buffer.sv
// Self-checking bench for sensor_matrix_scan_double_buffer: streams scan commands in, predicts
// each result here and compares the output stream field by field with it or a hand-written one.
// Depends on hw/rtl/smsdb_pkg.sv and hw/rtl/sensor_matrix_scan_double_buffer.sv.
module tb_sensor_matrix_scan_double_buffer;
	import smsdb_pkg::*;

	// One input command, unpacked from the s_tdata layout.
	typedef struct packed {
		op_t                 op;
		logic [SAMPLE_W-1:0] a;
		logic [SAMPLE_W-1:0] b;
		logic [SAMPLE_W-1:0] c;
		logic                rbank;
		logic [COL_W-1:0]    rcol;
		logic [ROW_W-1:0]    rrow;
	} scan_cmd_t;

	// One result, unpacked from the m_tdata layout.
	typedef struct packed {
		logic [SAMPLE_W-1:0] value;
		logic [COL_W-1:0]    col;
		logic [ROW_W-1:0]    row;
		logic                line_sync;
		logic                frame_sync;
		status_t             status;
		logic                bank;
	} scan_result_t;

	// A directed row carries a hand-written result only where has_fixed is set;
	// the others are checked against the prediction.
	typedef struct packed {
		scan_cmd_t    cmd;
		logic         has_fixed;
		scan_result_t res;
	} table_row_t;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [47:0] s_tdata;
	logic        m_tvalid;
	logic        m_tready;
	logic [31:0] m_tdata;

	sensor_matrix_scan_double_buffer dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Predicted scan state. It is updated when a command transfer is accepted, so it
	// runs ahead of the block's output by the commands still in flight.
	logic [COL_W-1:0]    pred_col;
	logic [ROW_W-1:0]    pred_row;
	logic                pred_bank;
	logic                pred_line;
	logic                pred_frame;
	status_t             pred_status;
	logic [SAMPLE_W-1:0] cell_mem [2][COLS][ROWS];
	bit                  cell_written [2][COLS][ROWS];
	bit                  any_written;
	int                  frame_wraps;

	scan_result_t pending_results[$];
	int           errors;
	int           sent_count;
	int           recv_count;
	bit           send_calm;
	bit           recv_calm;

	// Advances the predicted state by one command and returns the result it causes.
	function automatic scan_result_t predict_scan_result(scan_cmd_t cmd);
		scan_result_t res;
		int sum;
		res = '0;
		res.col = pred_col;
		res.row = pred_row;
		case (cmd.op)
			OP_CONV: begin
				// The position moves first; the average lands on the new cell.
				if (int'(pred_col) == COLS - 1) begin
					pred_col = '0;
					if (int'(pred_row) == ROWS - 1) begin
						// Frame wrap: only the frame sync toggles, the line sync holds.
						pred_row = '0;
						pred_frame = ~pred_frame;
						pred_bank = ~pred_bank;
						if (pred_status == ST_READY || pred_status == ST_OVERRUN)
							pred_status = ST_OVERRUN;
						else
							pred_status = ST_READY;
						frame_wraps++;
					end else begin
						pred_row = pred_row + 1'b1;
						pred_line = ~pred_line;
					end
				end else begin
					pred_col = pred_col + 1'b1;
				end
				sum = int'(cmd.a) + int'(cmd.b) + int'(cmd.c);
				res.value = SAMPLE_W'(sum / 3);
				cell_mem[pred_bank][pred_col][pred_row] = res.value;
				cell_written[pred_bank][pred_col][pred_row] = 1'b1;
				any_written = 1'b1;
				res.col = pred_col;
				res.row = pred_row;
			end
			OP_READ: begin
				if (int'(cmd.rcol) < COLS && int'(cmd.rrow) < ROWS)
					res.value = cell_mem[cmd.rbank][cmd.rcol][cmd.rrow];
				res.col = cmd.rcol;
				res.row = cmd.rrow;
			end
			OP_CLEAR: pred_status = ST_NONE;
			default: ;
		endcase
		res.line_sync = pred_line;
		res.frame_sync = pred_frame;
		res.status = pred_status;
		res.bank = pred_bank;
		return res;
	endfunction

	// Samples lean toward the ends of the range so that full-scale sums show up often.
	function automatic logic [SAMPLE_W-1:0] pick_sample();
		int r;
		r = $urandom_range(0, 7);
		if (r == 0)
			return '0;
		if (r == 1)
			return '1;
		return SAMPLE_W'($urandom_range(0, (1 << SAMPLE_W) - 1));
	endfunction

	function automatic scan_cmd_t random_cmd();
		scan_cmd_t cmd;
		int pick;
		int clear_pct;
		int tries;
		cmd.a = pick_sample();
		cmd.b = pick_sample();
		cmd.c = pick_sample();
		cmd.rbank = 1'($urandom_range(0, 1));
		cmd.rcol = COL_W'($urandom_range(0, COLS - 1));
		cmd.rrow = ROW_W'($urandom_range(0, ROWS - 1));
		// Clears are held back in every other frame so that the status raised by a
		// frame wrap stays visible, and allowed in the rest to reset it.
		clear_pct = (frame_wraps % 2 == 0) ? 5 : 0;
		pick = $urandom_range(0, 99);
		if (pick < 20) begin
			cmd.op = OP_READ;
			// A read must hit a cell that has been written since reset. The
			// current scan position always is, once any conversion has happened.
			tries = 0;
			while (tries < 8 && !cell_written[cmd.rbank][cmd.rcol][cmd.rrow]) begin
				cmd.rbank = 1'($urandom_range(0, 1));
				cmd.rcol = COL_W'($urandom_range(0, COLS - 1));
				cmd.rrow = ROW_W'($urandom_range(0, ROWS - 1));
				tries++;
			end
			if (!cell_written[cmd.rbank][cmd.rcol][cmd.rrow]) begin
				cmd.rbank = pred_bank;
				cmd.rcol = pred_col;
				cmd.rrow = pred_row;
			end
			if (!any_written)
				cmd.op = OP_CONV;
		end else if (pick < 20 + clear_pct) begin
			cmd.op = OP_CLEAR;
		end else if (pick < 24 + clear_pct) begin
			cmd.op = OP_UNUSED;
		end else begin
			cmd.op = OP_CONV;
		end
		return cmd;
	endfunction

	// Offers one command after a random gap and, once the transfer is accepted,
	// queues the result it must cause. tvalid is only lowered when a gap follows,
	// so back-to-back commands never see it dropped and raised in the same step.
	task automatic send_cmd(input scan_cmd_t cmd, input logic has_fixed,
			input scan_result_t fixed_res);
		scan_result_t res;
		int gap;
		gap = send_calm ? 0 : $urandom_range(0, 10);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {1'b0, cmd.rrow, cmd.rcol, cmd.rbank, cmd.c, cmd.b, cmd.a, cmd.op};
		do @(posedge clk); while (s_tready !== 1'b1);
		res = predict_scan_result(cmd);
		pending_results.push_back(has_fixed ? fixed_res : res);
		sent_count++;
		// Now and then a run of commands goes out with no gaps at all.
		if (sent_count % 32 == 0)
			send_calm = ($urandom_range(0, 3) == 0);
	endtask

	// Directed commands, starting from the reset state. Rows with hand-written
	// results cover reset, full-scale and zero averages and their read-back.
	table_row_t directed_rows [18] = '{
		'{'{OP_UNUSED, 12'hABC, 12'h123, 12'hFFF, 1'b1, 4'd15, 4'd15}, 1'b1,
			'{12'd0, 4'd0, 4'd0, 1'b0, 1'b0, ST_NONE, 1'b0}},
		'{'{OP_CLEAR, 12'hFFF, 12'hFFF, 12'hFFF, 1'b1, 4'd15, 4'd0}, 1'b1,
			'{12'd0, 4'd0, 4'd0, 1'b0, 1'b0, ST_NONE, 1'b0}},
		// The first conversion after reset lands on column 1, not column 0.
		'{'{OP_CONV, 12'hFFF, 12'hFFF, 12'hFFF, 1'b0, 4'd0, 4'd0}, 1'b1,
			'{12'd4095, 4'd1, 4'd0, 1'b0, 1'b0, ST_NONE, 1'b0}},
		'{'{OP_CONV, 12'h000, 12'h000, 12'h000, 1'b1, 4'd15, 4'd15}, 1'b1,
			'{12'd0, 4'd2, 4'd0, 1'b0, 1'b0, ST_NONE, 1'b0}},
		'{'{OP_READ, 12'h000, 12'h000, 12'h000, 1'b0, 4'd1, 4'd0}, 1'b1,
			'{12'd4095, 4'd1, 4'd0, 1'b0, 1'b0, ST_NONE, 1'b0}},
		'{'{OP_READ, 12'hFFF, 12'hFFF, 12'hFFF, 1'b0, 4'd2, 4'd0}, 1'b1,
			'{12'd0, 4'd2, 4'd0, 1'b0, 1'b0, ST_NONE, 1'b0}},
		// Truncating averages just below, just above and on a multiple of three.
		'{'{OP_CONV, 12'hFFF, 12'hFFF, 12'hFFE, 1'b0, 4'd0, 4'd0}, 1'b0, '0},
		'{'{OP_CONV, 12'h001, 12'h001, 12'h000, 1'b0, 4'd0, 4'd0}, 1'b0, '0},
		'{'{OP_CONV, 12'h002, 12'h002, 12'h001, 1'b0, 4'd0, 4'd0}, 1'b0, '0},
		'{'{OP_CONV, 12'h800, 12'h7FF, 12'h001, 1'b1, 4'd10, 4'd5}, 1'b0, '0},
		'{'{OP_CONV, 12'h555, 12'hAAA, 12'h000, 1'b0, 4'd5, 4'd10}, 1'b0, '0},
		'{'{OP_READ, 12'h000, 12'h000, 12'h000, 1'b0, 4'd3, 4'd0}, 1'b0, '0},
		'{'{OP_READ, 12'hFFF, 12'h000, 12'hFFF, 1'b0, 4'd7, 4'd0}, 1'b0, '0},
		'{'{OP_CLEAR, 12'h000, 12'h000, 12'h000, 1'b0, 4'd0, 4'd0}, 1'b0, '0},
		'{'{OP_UNUSED, 12'h000, 12'hFFF, 12'h000, 1'b0, 4'd8, 4'd8}, 1'b0, '0},
		'{'{OP_CONV, 12'hFFF, 12'h000, 12'h000, 1'b0, 4'd0, 4'd0}, 1'b0, '0},
		'{'{OP_READ, 12'h000, 12'h000, 12'h000, 1'b0, 4'd6, 4'd0}, 1'b0, '0},
		'{'{OP_READ, 12'h000, 12'h000, 12'h000, 1'b0, 4'd8, 4'd0}, 1'b0, '0}
	};

	// Result side: draws a stall before each result, then takes one transfer and
	// checks it against the oldest queued expectation.
	initial begin : result_sink
		scan_result_t got;
		scan_result_t want;
		int gap;
		m_tready <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			gap = recv_calm ? 0 : $urandom_range(0, 10);
			if (gap > 0) begin
				m_tready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (m_tvalid !== 1'b1);
			got.value = m_tdata[11:0];
			got.col = m_tdata[15:12];
			got.row = m_tdata[19:16];
			got.line_sync = m_tdata[20];
			got.frame_sync = m_tdata[21];
			got.status = status_t'(m_tdata[23:22]);
			got.bank = m_tdata[24];
			if (pending_results.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("unexpected result transfer, m_tdata %h", m_tdata);
			end else begin
				want = pending_results.pop_front();
				if (got.value !== want.value || got.col !== want.col || got.row !== want.row
						|| got.line_sync !== want.line_sync
						|| got.frame_sync !== want.frame_sync
						|| got.status !== want.status || got.bank !== want.bank) begin
					errors++;
					if (errors <= 10) begin
						$display("result %0d mismatch", recv_count);
						$display("  expected value %0d col %0d row %0d line %b frame %b status %0d bank %b",
							want.value, want.col, want.row, want.line_sync, want.frame_sync,
							want.status, want.bank);
						$display("  got      value %0d col %0d row %0d line %b frame %b status %0d bank %b",
							got.value, got.col, got.row, got.line_sync, got.frame_sync,
							got.status, got.bank);
					end
				end
			end
			recv_count++;
			if (recv_count % 32 == 0)
				recv_calm = ($urandom_range(0, 3) == 0);
		end
	end

	// Command side: reset, the directed table, then a fixed number of random
	// commands, enough to wrap a frame and flip to the second bank.
	initial begin : stimulus
		scan_cmd_t cmd;
		int rand_items;
		arst_n <= 1'b0;
		s_tvalid <= 1'b0;
		s_tdata <= '0;
		pred_col = '0;
		pred_row = '0;
		pred_bank = 1'b0;
		pred_line = 1'b0;
		pred_frame = 1'b0;
		pred_status = ST_NONE;
		any_written = 1'b0;
		frame_wraps = 0;
		errors = 0;
		sent_count = 0;
		recv_count = 0;
		send_calm = 1'b0;
		recv_calm = 1'b0;
		rand_items = 0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[i])
			send_cmd(directed_rows[i].cmd, directed_rows[i].has_fixed, directed_rows[i].res);

		while (rand_items < 400) begin
			cmd = random_cmd();
			send_cmd(cmd, 1'b0, '0);
			rand_items++;
		end
		s_tvalid <= 1'b0;

		// Drain the pipeline, then keep the clock running so that any stray result shows.
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
		if (errors == 0)
			$display("PASS sensor_matrix_scan_double_buffer");
		else
			$display("FAIL sensor_matrix_scan_double_buffer");
		$finish;
	end

	// Hard stop in case a handshake never completes.
	initial begin : watchdog
		#3000000;
		$display("FAIL sensor_matrix_scan_double_buffer");
		$finish;
	end

endmodule

FILE: files.f
hw/rtl/smsdb_pkg.sv
hw/rtl/sensor_matrix_scan_double_buffer.sv
bench/tb_sensor_matrix_scan_double_buffer.sv
